>>> rtl/subnet_host_traffic_meter_core_macros.svh
// Assertion macros for the subnet host traffic meter checker.
// Included by the checker file; no other dependencies.
`ifndef SUBNET_HOST_TRAFFIC_METER_CORE_MACROS_SVH
`define SUBNET_HOST_TRAFFIC_METER_CORE_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define SHTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication under asynchronous active-low reset
`define SHTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/shtm_pkg.sv
// Shared types, codes and constants of the subnet host traffic meter.
// No dependencies.
package shtm_pkg;

	localparam int HOSTS            = 256;
	localparam int HOST_W           = $clog2(HOSTS);
	localparam int INTERVAL_SECONDS = 5;

	localparam int DIV_SHIFT = 32 + $clog2(INTERVAL_SECONDS);
	localparam logic [65:0] DIV_NUM =
		(66'd1 << DIV_SHIFT) + 66'(INTERVAL_SECONDS - 1);
	localparam logic [32:0] DIV_MAGIC = 33'(DIV_NUM / 66'(INTERVAL_SECONDS));

	localparam logic [1:0] OP_PACKET  = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_OFFLINE = 2'd2;
	localparam logic [1:0] OP_QUERY   = 2'd3;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_SRC  = 2'd1;
	localparam logic [1:0] CNT_DST  = 2'd2;

	localparam logic [1:0] REG_PREFIX  = 2'd0;
	localparam logic [1:0] REG_GATEWAY = 2'd1;
	localparam logic [1:0] REG_IDLE    = 2'd2;

	localparam logic [15:0] IPV4_TYPE = 16'h0800;
	localparam logic [HOST_W-1:0] FIRST_AGED = HOST_W'(2);
	localparam logic [HOST_W-1:0] LAST_AGED  = HOST_W'(254);

	localparam logic [23:0] PREFIX_RST  = 24'hC0A828;
	localparam logic [7:0]  GATEWAY_RST = 8'd1;
	localparam logic [4:0]  IDLE_RST    = 5'd20;

	typedef struct packed {
		logic [31:0] src_delta;
		logic [31:0] dst_delta;
		logic [31:0] src_rate;
		logic [31:0] dst_rate;
		logic [4:0]  age;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [HOST_W-1:0] addr;
		entry_t            data;
	} mem_wr_t;

endpackage

>>> rtl/shtm_mem.sv
// Per-host entry memory: one write port, one registered read port.
// Depends on shtm_pkg.
module shtm_mem (
	input  logic                             clk,
	input  shtm_pkg::mem_wr_t                wr,
	input  logic [shtm_pkg::HOST_W-1:0]      rd_addr,
	output shtm_pkg::entry_t                 rd_data
);

	shtm_pkg::entry_t mem_q [shtm_pkg::HOSTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/shtm_div.sv
// Constant divider by the interval length via reciprocal multiply, one register.
// Depends on shtm_pkg.
module shtm_div (
	input  logic        clk,
	input  logic [31:0] x,
	output logic [31:0] q
);

	logic [64:0] prod;

	assign prod = 65'(x) * 65'(shtm_pkg::DIV_MAGIC);

	always_ff @(posedge clk) begin
		q <= 32'(prod >> shtm_pkg::DIV_SHIFT);
	end

endmodule

>>> rtl/subnet_host_traffic_meter_core.sv
// Top level of the subnet host traffic meter.
// Depends on shtm_pkg, shtm_mem and shtm_div.
//
// Usage: drive an item on the input ports with start high; it is taken at a
// clock edge where busy is low. Exactly one result follows per item, shown
// for one cycle with done high; the receiver cannot stall, so done is never
// held. Packet, offline and query items read the host entry; packet items
// that are counted and offline items then modify and write it back, with the
// result on done the cycle after. A tick walks all 256 host entries in turn,
// each read, then divided and written back. After reset busy stays high while
// all 256 entries of the entry memory are cleared; configuration writes are
// taken at any time through cfg_we, cfg_idx and cfg_wdata. Per-host counters
// hold the bytes since the last tick, so no separate snapshot table is needed.
module subnet_host_traffic_meter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] ether_type,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] capture_length,
	input  logic [7:0]  host,
	output logic        done,
	output logic [1:0]  counted_as,
	output logic        host_online,
	output logic [4:0]  host_age,
	output logic [31:0] rate_src,
	output logic [31:0] rate_dst
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_TCALC = 5'b01000,
		ST_TWR   = 5'b10000
	} state_t;

	state_t state_q;
	logic [23:0] prefix_q;
	logic [7:0]  gateway_q;
	logic [4:0]  idle_q;
	logic [7:0]  ptr_q;
	logic [1:0]  op_q;
	logic [1:0]  cnt_q;
	logic [15:0] len_q;
	logic        done_q;
	logic [1:0]  counted_q;
	logic        online_q;
	logic [4:0]  age_q;
	logic [31:0] rsrc_q;
	logic [31:0] rdst_q;

	logic [4:0]  age_s1;
	logic        aged_s1;
	logic [31:0] old_src_s1;
	logic [31:0] old_dst_s1;

	shtm_pkg::mem_wr_t wr;
	shtm_pkg::entry_t  rd_data;
	shtm_pkg::entry_t  upd;
	logic [7:0]  rd_addr;
	logic        accept;
	logic        ipv4, src_hit, dst_hit;
	logic        changed, aged;
	logic [4:0]  age_inc, new_age;
	logic [31:0] q_src, q_dst;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign ipv4    = (ether_type == shtm_pkg::IPV4_TYPE);
	assign src_hit = ipv4 && (src_addr[31:8] == prefix_q) && (src_addr[7:0] != gateway_q);
	assign dst_hit = ipv4 && (dst_addr[31:8] == prefix_q) && (dst_addr[7:0] != gateway_q);

	assign changed = (rd_data.src_delta != 32'd0) || (rd_data.dst_delta != 32'd0);
	assign aged    = (ptr_q >= shtm_pkg::FIRST_AGED) && (ptr_q <= shtm_pkg::LAST_AGED);
	assign age_inc = rd_data.age + 5'd1;

	always_comb begin
		if (changed) begin
			new_age = 5'd1;
		end else if (rd_data.age == 5'd0) begin
			new_age = 5'd0;
		end else if (age_inc == idle_q) begin
			new_age = 5'd0;
		end else begin
			new_age = age_inc;
		end
	end

	shtm_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	shtm_div u_div_src (
		.clk (clk),
		.x   (rd_data.src_delta),
		.q   (q_src)
	);

	shtm_div u_div_dst (
		.clk (clk),
		.x   (rd_data.dst_delta),
		.q   (q_dst)
	);

	always_comb begin
		rd_addr = ptr_q + 8'd1;
		if (state_q == ST_IDLE) begin
			case (opcode)
				shtm_pkg::OP_PACKET: rd_addr = src_hit ? src_addr[7:0] : dst_addr[7:0];
				shtm_pkg::OP_TICK:   rd_addr = 8'd0;
				default:             rd_addr = host;
			endcase
		end
	end

	always_comb begin
		upd     = rd_data;
		wr.en   = 1'b0;
		wr.addr = ptr_q;
		wr.data = rd_data;
		case (state_q)
			ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.data = '0;
			end
			ST_EXEC: begin
				if (op_q == shtm_pkg::OP_PACKET) begin
					if (cnt_q == shtm_pkg::CNT_SRC) begin
						upd.src_delta = rd_data.src_delta + 32'(len_q);
					end else begin
						upd.dst_delta = rd_data.dst_delta + 32'(len_q);
					end
					wr.en = (cnt_q != shtm_pkg::CNT_NONE);
				end else if (op_q == shtm_pkg::OP_OFFLINE) begin
					upd.age = 5'd0;
					wr.en   = 1'b1;
				end
				wr.data = upd;
			end
			ST_TWR: begin
				wr.en             = 1'b1;
				wr.data.src_delta = 32'd0;
				wr.data.dst_delta = 32'd0;
				wr.data.age       = age_s1;
				if (!aged_s1) begin
					wr.data.src_rate = old_src_s1;
					wr.data.dst_rate = old_dst_s1;
				end else if (age_s1 == 5'd1) begin
					wr.data.src_rate = q_src;
					wr.data.dst_rate = q_dst;
				end else begin
					wr.data.src_rate = 32'd0;
					wr.data.dst_rate = 32'd0;
				end
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q  <= shtm_pkg::PREFIX_RST;
			gateway_q <= shtm_pkg::GATEWAY_RST;
			idle_q    <= shtm_pkg::IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				shtm_pkg::REG_PREFIX:  prefix_q  <= cfg_wdata;
				shtm_pkg::REG_GATEWAY: gateway_q <= cfg_wdata[7:0];
				shtm_pkg::REG_IDLE:    idle_q    <= cfg_wdata[4:0];
				default:               idle_q    <= idle_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= 8'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 8'd1;
					if (ptr_q == 8'hFF) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ptr_q   <= rd_addr;
						state_q <= (opcode == shtm_pkg::OP_TICK) ? ST_TCALC : ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_TCALC: begin
					state_q <= ST_TWR;
				end
				ST_TWR: begin
					ptr_q <= ptr_q + 8'd1;
					if (ptr_q == 8'hFF) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TCALC;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			len_q <= capture_length;
			if (src_hit) begin
				cnt_q <= shtm_pkg::CNT_SRC;
			end else if (dst_hit) begin
				cnt_q <= shtm_pkg::CNT_DST;
			end else begin
				cnt_q <= shtm_pkg::CNT_NONE;
			end
		end
		if (state_q == ST_TCALC) begin
			aged_s1    <= aged;
			age_s1     <= aged ? new_age : rd_data.age;
			old_src_s1 <= rd_data.src_rate;
			old_dst_s1 <= rd_data.dst_rate;
		end
		if (state_q == ST_EXEC || state_q == ST_TWR) begin
			counted_q <= 2'd0;
			online_q  <= 1'b0;
			age_q     <= 5'd0;
			rsrc_q    <= 32'd0;
			rdst_q    <= 32'd0;
			if (state_q == ST_EXEC && op_q == shtm_pkg::OP_PACKET) begin
				counted_q <= cnt_q;
			end
			if (state_q == ST_EXEC && op_q == shtm_pkg::OP_QUERY) begin
				online_q <= (rd_data.age != 5'd0);
				age_q    <= rd_data.age;
				if (rd_data.age != 5'd0) begin
					rsrc_q <= rd_data.src_rate;
					rdst_q <= rd_data.dst_rate;
				end
			end
		end
	end

	assign done        = done_q;
	assign counted_as  = counted_q;
	assign host_online = online_q;
	assign host_age    = age_q;
	assign rate_src    = rsrc_q;
	assign rate_dst    = rdst_q;

endmodule

>>> rtl/shtm_checker.sv
// Port-level checker for the subnet host traffic meter, bound to the top level.
// Depends on subnet_host_traffic_meter_core_macros.svh.
`include "subnet_host_traffic_meter_core_macros.svh"

module shtm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  counted_as,
	input logic        host_online,
	input logic [4:0]  host_age
);

	`SHTM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SHTM_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`SHTM_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`SHTM_ASSERT_SAME(a_code_range, clk, arst_n, done, counted_as != 2'd3)
	`SHTM_ASSERT_SAME(a_online_age, clk, arst_n, done, host_online == (host_age != 5'd0))

endmodule

bind subnet_host_traffic_meter_core shtm_checker u_shtm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.counted_as  (counted_as),
	.host_online (host_online),
	.host_age    (host_age)
);
